// ===== hw/rtl/tnsc_pkg.sv =====
package tnsc_pkg;

    localparam int COORD_W    = 24;                 // vertex and centroid coordinates
    localparam int DIFF_W     = COORD_W + 1;        // edge vectors
    localparam int SUM_W      = COORD_W + 2;        // sum of three coordinates
    localparam int PROD_W     = 2 * DIFF_W;         // cross product terms
    localparam int MAG_W      = PROD_W - 1;         // |n| < 2^49
    localparam int LO_W       = 25;                 // low half of a magnitude
    localparam int HI_W       = MAG_W - LO_W;       // high half of a magnitude
    localparam int SQ_W       = 2 * MAG_W;          // square of one component
    localparam int SUMSQ_W    = SQ_W + 2;           // sum of three squares
    localparam int ROOT_W     = SUMSQ_W / 2;        // floor(sqrt) width
    localparam int REM_W      = ROOT_W + 1;         // division remainder
    localparam int FRAC_BITS  = 14;
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int UNIT_W     = 16;
    localparam int UNIT_ONE   = 16384;
    localparam int LEVEL_W    = 15;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int LABEL_W    = 2;

    // sum / 3 as (|sum| * DIV3_K) >> DIV3_SHIFT, exact for |sum| < 2^25
    localparam int DIV3_SHIFT = 26;
    localparam int DIV3_W     = 25;
    localparam logic [DIV3_W-1:0] DIV3_K = DIV3_W'((2 ** DIV3_SHIFT + 2) / 3);

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLAT_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEEP_LEVEL  = 2'd2;

    localparam logic signed [COORD_W-1:0] HEIGHT_LIMIT_RST = 24'sd512;
    localparam logic [LEVEL_W-1:0]        FLAT_LEVEL_RST   = 15'd16220;
    localparam logic [LEVEL_W-1:0]        STEEP_LEVEL_RST  = 15'd819;

    localparam logic [LABEL_W-1:0] LABEL_GROUND     = 2'd0;
    localparam logic [LABEL_W-1:0] LABEL_NON_GROUND = 2'd1;
    localparam logic [LABEL_W-1:0] LABEL_BOUNDARY   = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic signed [COORD_W-1:0] mid_z;
        logic signed [UNIT_W-1:0]  unit_x;
        logic signed [UNIT_W-1:0]  unit_y;
        logic signed [UNIT_W-1:0]  unit_z;
        logic [LABEL_W-1:0]        terrain_label;
    } tri_out_t;

endpackage

// ===== hw/rtl/triangle_normal_slope_classifier.sv =====
// Fully pipelined: one triangle is taken in every cycle (busy never rises) and
// its result appears with done, in input order. The pipeline holds the 50-stage
// square root, one result bit per stage, followed by the 15-stage restoring
// divider for the unit normal.
// done is a single-cycle strobe; the receiver must take result in that cycle.
// Register writes through wr_en/wr_index/wr_data take effect at the next edge and
// belong in times when no triangle is in flight.
module triangle_normal_slope_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  tnsc_pkg::tri_in_t                   vertices,
    output logic                                done,
    output tnsc_pkg::tri_out_t                  result,
    input  logic                                wr_en,
    input  logic [tnsc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [tnsc_pkg::CFG_W-1:0]          wr_data
);
    import tnsc_pkg::*;

    localparam int LATENCY = 7 + ROOT_W + QUOT_W + 1;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] mid;
        logic                    any_high;
        logic                    all_high;
        logic [2:0]              neg;
        logic [2:0][MAG_W-1:0]   mag;
    } side_t;

    // ---------------- configuration ----------------
    logic signed [COORD_W-1:0] height_limit_reg;
    logic [LEVEL_W-1:0]        flat_level_reg;
    logic [LEVEL_W-1:0]        steep_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_limit_reg <= HEIGHT_LIMIT_RST;
            flat_level_reg   <= FLAT_LEVEL_RST;
            steep_level_reg  <= STEEP_LEVEL_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_HEIGHT_LIMIT: height_limit_reg <= signed'(wr_data[COORD_W-1:0]);
                REG_FLAT_LEVEL:   flat_level_reg   <= wr_data[LEVEL_W-1:0];
                REG_STEEP_LEVEL:  steep_level_reg  <= wr_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- valid chain for the front stages ----------------
    logic [5:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], start};
    end

    // ---------------- stage 1: edges, sums, height flags ----------------
    logic signed [DIFF_W-1:0] ab_next [3];
    logic signed [DIFF_W-1:0] cb_next [3];
    logic signed [SUM_W-1:0]  sum_next [3];
    logic [2:0]               high_next;
    logic signed [COORD_W-1:0] pa [3];
    logic signed [COORD_W-1:0] pb [3];
    logic signed [COORD_W-1:0] pc [3];

    always_comb
    begin
        pa[0] = vertices.a_x; pa[1] = vertices.a_y; pa[2] = vertices.a_z;
        pb[0] = vertices.b_x; pb[1] = vertices.b_y; pb[2] = vertices.b_z;
        pc[0] = vertices.c_x; pc[1] = vertices.c_y; pc[2] = vertices.c_z;
        for (int i = 0; i < 3; i++)
        begin
            ab_next[i]  = DIFF_W'(pb[i]) - DIFF_W'(pa[i]);
            cb_next[i]  = DIFF_W'(pb[i]) - DIFF_W'(pc[i]);
            sum_next[i] = SUM_W'(pa[i]) + SUM_W'(pb[i]) + SUM_W'(pc[i]);
        end
        high_next[0] = vertices.a_z > height_limit_reg;
        high_next[1] = vertices.b_z > height_limit_reg;
        high_next[2] = vertices.c_z > height_limit_reg;
    end

    logic signed [DIFF_W-1:0] s1_ab_reg [3];
    logic signed [DIFF_W-1:0] s1_cb_reg [3];
    logic signed [SUM_W-1:0]  s1_sum_reg [3];
    logic [2:0]               s1_high_reg;

    always_ff @(posedge clk)
    begin
        s1_ab_reg   <= ab_next;
        s1_cb_reg   <= cb_next;
        s1_sum_reg  <= sum_next;
        s1_high_reg <= high_next;
    end

    // ---------------- stage 2: cross terms, centroid reciprocal ----------------
    logic signed [PROD_W-1:0] s2_p_reg [6];
    logic [PROD_W-1:0]        s2_m3_reg [3];
    logic [2:0]               s2_sneg_reg;
    logic [2:0]               s2_high_reg;
    logic [DIV3_W-1:0]        sabs [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sabs[i] = DIV3_W'(s1_sum_reg[i] < 0 ? -s1_sum_reg[i] : s1_sum_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        s2_p_reg[0] <= PROD_W'(s1_ab_reg[1]) * PROD_W'(s1_cb_reg[2]);
        s2_p_reg[1] <= PROD_W'(s1_ab_reg[2]) * PROD_W'(s1_cb_reg[1]);
        s2_p_reg[2] <= PROD_W'(s1_ab_reg[2]) * PROD_W'(s1_cb_reg[0]);
        s2_p_reg[3] <= PROD_W'(s1_ab_reg[0]) * PROD_W'(s1_cb_reg[2]);
        s2_p_reg[4] <= PROD_W'(s1_ab_reg[0]) * PROD_W'(s1_cb_reg[1]);
        s2_p_reg[5] <= PROD_W'(s1_ab_reg[1]) * PROD_W'(s1_cb_reg[0]);
        for (int i = 0; i < 3; i++)
        begin
            s2_m3_reg[i]   <= PROD_W'(sabs[i]) * PROD_W'(DIV3_K);
            s2_sneg_reg[i] <= s1_sum_reg[i][SUM_W-1];
        end
        s2_high_reg <= s1_high_reg;
    end

    // ---------------- stage 3: normal, centroid ----------------
    logic signed [PROD_W-1:0] s3_n_reg [3];
    logic [2:0][COORD_W-1:0]  s3_mid_reg;
    logic [2:0]               s3_high_reg;
    logic [COORD_W-1:0]       quo3 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            quo3[i] = s2_m3_reg[i][DIV3_SHIFT +: COORD_W];
    end

    always_ff @(posedge clk)
    begin
        s3_n_reg[0] <= s2_p_reg[1] - s2_p_reg[0];
        s3_n_reg[1] <= s2_p_reg[3] - s2_p_reg[2];
        s3_n_reg[2] <= s2_p_reg[5] - s2_p_reg[4];
        for (int i = 0; i < 3; i++)
            s3_mid_reg[i] <= s2_sneg_reg[i] ? -quo3[i] : quo3[i];
        s3_high_reg <= s2_high_reg;
    end

    // ---------------- stage 4: magnitudes ----------------
    side_t s4_side_reg;
    always_ff @(posedge clk)
    begin
        s4_side_reg.mid      <= s3_mid_reg;
        s4_side_reg.any_high <= |s3_high_reg;
        s4_side_reg.all_high <= &s3_high_reg;
        for (int i = 0; i < 3; i++)
        begin
            s4_side_reg.neg[i] <= s3_n_reg[i][PROD_W-1];
            s4_side_reg.mag[i] <= MAG_W'(s3_n_reg[i] < 0 ? -s3_n_reg[i] : s3_n_reg[i]);
        end
    end

    // ---------------- stage 5: partial squares ----------------
    side_t                s5_side_reg;
    logic [2*HI_W-1:0]    s5_hh_reg [3];
    logic [HI_W+LO_W-1:0] s5_hl_reg [3];
    logic [2*LO_W-1:0]    s5_ll_reg [3];

    always_ff @(posedge clk)
    begin
        s5_side_reg <= s4_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            s5_hh_reg[i] <= (2*HI_W)'(s4_side_reg.mag[i][MAG_W-1:LO_W])
                            * (2*HI_W)'(s4_side_reg.mag[i][MAG_W-1:LO_W]);
            s5_hl_reg[i] <= (HI_W+LO_W)'(s4_side_reg.mag[i][MAG_W-1:LO_W])
                            * (HI_W+LO_W)'(s4_side_reg.mag[i][LO_W-1:0]);
            s5_ll_reg[i] <= (2*LO_W)'(s4_side_reg.mag[i][LO_W-1:0])
                            * (2*LO_W)'(s4_side_reg.mag[i][LO_W-1:0]);
        end
    end

    // ---------------- stage 6: component squares ----------------
    side_t           s6_side_reg;
    logic [SQ_W-1:0] s6_sq_reg [3];

    always_ff @(posedge clk)
    begin
        s6_side_reg <= s5_side_reg;
        for (int i = 0; i < 3; i++)
            s6_sq_reg[i] <= (SQ_W'(s5_hh_reg[i]) << (2 * LO_W))
                          + (SQ_W'(s5_hl_reg[i]) << (LO_W + 1))
                          + SQ_W'(s5_ll_reg[i]);
    end

    // ---------------- stage 7 feeds the root: squared length ----------------
    logic                 sqv_reg   [0:ROOT_W];
    logic [SUMSQ_W-1:0]   sqrem_reg [0:ROOT_W];
    logic [ROOT_W-1:0]    sqres_reg [0:ROOT_W];
    side_t                sqside_reg [0:ROOT_W];

    always_ff @(posedge clk)
    begin
        sqrem_reg[0]  <= SUMSQ_W'(s6_sq_reg[0]) + SUMSQ_W'(s6_sq_reg[1])
                       + SUMSQ_W'(s6_sq_reg[2]);
        sqres_reg[0]  <= '0;
        sqside_reg[0] <= s6_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqv_reg[0] <= 1'b0;
        else
            sqv_reg[0] <= v_reg[5];
    end

    // one root bit per stage, most significant first
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        localparam int BIT = ROOT_W - 1 - k;
        logic [SUMSQ_W-1:0] trial;
        logic               fits;

        assign trial = (SUMSQ_W'(sqres_reg[k]) << (BIT + 1)) | (SUMSQ_W'(1) << (2 * BIT));
        assign fits  = sqrem_reg[k] >= trial;

        always_ff @(posedge clk)
        begin
            sqrem_reg[k+1]  <= fits ? sqrem_reg[k] - trial : sqrem_reg[k];
            sqres_reg[k+1]  <= sqres_reg[k] | (ROOT_W'(fits) << BIT);
            sqside_reg[k+1] <= sqside_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sqv_reg[k+1] <= 1'b0;
            else
                sqv_reg[k+1] <= sqv_reg[k];
        end
    end

    // ---------------- restoring division, three lanes ----------------
    logic              dvv_reg   [1:QUOT_W];
    logic [REM_W-1:0]  dvr_reg   [1:QUOT_W][3];
    logic [QUOT_W-1:0] dvq_reg   [1:QUOT_W][3];
    logic [ROOT_W-1:0] dvlen_reg [1:QUOT_W];
    side_t             dvside_reg [1:QUOT_W];

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_div
        logic              in_v;
        logic [REM_W-1:0]  in_r [3];
        logic [QUOT_W-1:0] in_q [3];
        logic [ROOT_W-1:0] in_len;
        side_t             in_side;
        logic [REM_W-1:0]  rs [3];
        logic [2:0]        ge;

        if (j == 0)
        begin : g_first
            assign in_v    = sqv_reg[ROOT_W];
            assign in_len  = sqres_reg[ROOT_W];
            assign in_side = sqside_reg[ROOT_W];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign in_r[i] = REM_W'(sqside_reg[ROOT_W].mag[i]);
                assign in_q[i] = '0;
            end
        end
        else
        begin : g_next
            assign in_v    = dvv_reg[j];
            assign in_len  = dvlen_reg[j];
            assign in_side = dvside_reg[j];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign in_r[i] = dvr_reg[j][i];
                assign in_q[i] = dvq_reg[j][i];
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rs[i] = (j == 0) ? in_r[i] : (in_r[i] << 1);
                ge[i] = rs[i] >= REM_W'(in_len);
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dvr_reg[j+1][i] <= ge[i] ? rs[i] - REM_W'(in_len) : rs[i];
                dvq_reg[j+1][i] <= {in_q[i][QUOT_W-2:0], ge[i]};
            end
            dvlen_reg[j+1]  <= in_len;
            dvside_reg[j+1] <= in_side;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dvv_reg[j+1] <= 1'b0;
            else
                dvv_reg[j+1] <= in_v;
        end
    end

    // ---------------- output stage: clamp, sign, label ----------------
    logic signed [UNIT_W-1:0] u_next [3];
    logic [QUOT_W-1:0]        qc;
    logic [UNIT_W-1:0]        uz_abs;
    logic [LABEL_W-1:0]       label_next;
    side_t                    fin;

    always_comb
    begin
        fin = dvside_reg[QUOT_W];
        for (int i = 0; i < 3; i++)
        begin
            qc = (dvq_reg[QUOT_W][i] > QUOT_W'(UNIT_ONE)) ? QUOT_W'(UNIT_ONE)
                                                         : dvq_reg[QUOT_W][i];
            if (dvlen_reg[QUOT_W] == '0)
                u_next[i] = '0;
            else if (fin.neg[i])
                u_next[i] = -UNIT_W'(qc);
            else
                u_next[i] = UNIT_W'(qc);
        end
        uz_abs = UNIT_W'(u_next[2] < 0 ? -u_next[2] : u_next[2]);
        if ((UNIT_W+1)'(u_next[2]) > signed'({2'b00, flat_level_reg}) && !fin.all_high)
            label_next = LABEL_GROUND;
        else if (uz_abs < UNIT_W'(steep_level_reg) || fin.any_high)
            label_next = LABEL_NON_GROUND;
        else
            label_next = LABEL_BOUNDARY;
    end

    logic     done_reg;
    tri_out_t result_reg;

    always_ff @(posedge clk)
    begin
        result_reg.mid_x         <= signed'(fin.mid[0]);
        result_reg.mid_y         <= signed'(fin.mid[1]);
        result_reg.mid_z         <= signed'(fin.mid[2]);
        result_reg.unit_x        <= u_next[0];
        result_reg.unit_y        <= u_next[1];
        result_reg.unit_z        <= u_next[2];
        result_reg.terrain_label <= label_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dvv_reg[QUOT_W];
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("triangle result missing at fixed latency");

    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sqv_reg[ROOT_W] |-> sqrem_reg[ROOT_W] <= (SUMSQ_W'(sqres_reg[ROOT_W]) << 1))
        else $error("square root remainder out of range");

    a_quot: assert property (@(posedge clk) disable iff (!rst_n)
        (dvv_reg[QUOT_W] && dvlen_reg[QUOT_W] != '0) |->
            (dvq_reg[QUOT_W][0] <= QUOT_W'(UNIT_ONE) && dvq_reg[QUOT_W][1] <= QUOT_W'(UNIT_ONE)
             && dvq_reg[QUOT_W][2] <= QUOT_W'(UNIT_ONE)))
        else $error("normal component exceeds unit length");

    a_unit_z: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.unit_z <= 16'sd16384 && result.unit_z >= -16'sd16384))
        else $error("unit_z out of range");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tnsc_pkg::*;

    localparam int PIPE_LATENCY = 73;
    localparam int STALL_LIMIT  = 4000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    tri_in_t  vertices;
    logic     done;
    tri_out_t result;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    // testbench copy of the configuration registers
    logic signed [COORD_W-1:0] lim_height;
    logic [LEVEL_W-1:0]        lvl_flat;
    logic [LEVEL_W-1:0]        lvl_steep;

    tri_out_t pending_results[$];
    int       mismatch_count;
    int       sent_count;
    int       checked_count;
    int       sender_idle_pct;
    int       stall_cycles;

    triangle_normal_slope_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .vertices (vertices),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic tri_out_t predict_triangle(tri_in_t t);
        longint p[9];
        longint ab[3];
        longint cb[3];
        longint n[3];
        longint u[3];
        longint sum;
        longint unsigned mag_n;
        longint unsigned len;
        longint unsigned r;
        longint unsigned q;
        logic [127:0] sumsq;
        logic [127:0] cand;
        logic [127:0] wide;
        bit any_hi;
        bit all_hi;
        tri_out_t o;
        p = '{t.a_x, t.a_y, t.a_z, t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z};
        for (int i = 0; i < 3; i++)
        begin
            sum = p[i] + p[3+i] + p[6+i];
            if (i == 0) o.mid_x = COORD_W'(sum / 3);
            if (i == 1) o.mid_y = COORD_W'(sum / 3);
            if (i == 2) o.mid_z = COORD_W'(sum / 3);
            ab[i] = p[3+i] - p[i];
            cb[i] = p[3+i] - p[6+i];
        end
        n[0] = -(ab[1] * cb[2] - ab[2] * cb[1]);
        n[1] = -(ab[2] * cb[0] - ab[0] * cb[2]);
        n[2] = -(ab[0] * cb[1] - ab[1] * cb[0]);
        sumsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag_n = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
            wide  = {64'd0, mag_n};
            sumsq = sumsq + wide * wide;
        end
        len = 0;
        for (int b = 52; b >= 0; b--)
        begin
            cand = {64'd0, len | (64'd1 << b)};
            if (cand * cand <= sumsq)
                len = cand[63:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
                u[i] = 0;
            else
            begin
                r = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
                q = 0;
                if (r >= len)
                begin
                    q = 1;
                    r = r - len;
                end
                for (int k = 0; k < FRAC_BITS; k++)
                begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= len)
                    begin
                        r = r - len;
                        q = q | 1;
                    end
                end
                if (q > UNIT_ONE)
                    q = UNIT_ONE;
                u[i] = (n[i] < 0) ? -longint'(q) : longint'(q);
            end
        end
        o.unit_x = UNIT_W'(u[0]);
        o.unit_y = UNIT_W'(u[1]);
        o.unit_z = UNIT_W'(u[2]);
        any_hi = p[2] > longint'(lim_height) || p[5] > longint'(lim_height)
                 || p[8] > longint'(lim_height);
        all_hi = p[2] > longint'(lim_height) && p[5] > longint'(lim_height)
                 && p[8] > longint'(lim_height);
        if (u[2] > longint'(lvl_flat) && !all_hi)
            o.terrain_label = LABEL_GROUND;
        else if (((u[2] < 0) ? -u[2] : u[2]) < longint'(lvl_steep) || any_hi)
            o.terrain_label = LABEL_NON_GROUND;
        else
            o.terrain_label = LABEL_BOUNDARY;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 checked_count, what, got, want);
        mismatch_count++;
    endtask

    // result checker and stall watchdog, sampled mid-cycle
    always @(negedge clk)
    begin
        tri_out_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("unexpected result with nothing pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.mid_x !== want.mid_x)
                        report_mismatch("mid_x", result.mid_x, want.mid_x);
                    if (result.mid_y !== want.mid_y)
                        report_mismatch("mid_y", result.mid_y, want.mid_y);
                    if (result.mid_z !== want.mid_z)
                        report_mismatch("mid_z", result.mid_z, want.mid_z);
                    if (result.unit_x !== want.unit_x)
                        report_mismatch("unit_x", result.unit_x, want.unit_x);
                    if (result.unit_y !== want.unit_y)
                        report_mismatch("unit_y", result.unit_y, want.unit_y);
                    if (result.unit_z !== want.unit_z)
                        report_mismatch("unit_z", result.unit_z, want.unit_z);
                    if (result.terrain_label !== want.terrain_label)
                        report_mismatch("terrain_label", result.terrain_label,
                                        want.terrain_label);
                    checked_count++;
                end
            end
        end
    end

    task automatic send_triangle(tri_in_t v);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start    <= 1'b1;
        vertices <= v;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        pending_results.insert(pending_results.size(), predict_triangle(v));
        sent_count++;
        @(posedge clk);
    endtask

    // hold off until every pending result has drained, plus pipeline depth
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_HEIGHT_LIMIT: lim_height = data;
            REG_FLAT_LEVEL:   lvl_flat   = data[LEVEL_W-1:0];
            REG_STEEP_LEVEL:  lvl_steep  = data[LEVEL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic tri_in_t make_tri(longint ax, longint ay, longint az,
                                         longint bx, longint by, longint bz,
                                         longint cx, longint cy, longint cz);
        tri_in_t t;
        t.a_x = COORD_W'(ax); t.a_y = COORD_W'(ay); t.a_z = COORD_W'(az);
        t.b_x = COORD_W'(bx); t.b_y = COORD_W'(by); t.b_z = COORD_W'(bz);
        t.c_x = COORD_W'(cx); t.c_y = COORD_W'(cy); t.c_z = COORD_W'(cz);
        return t;
    endfunction

    function automatic longint jitter(longint base, int span);
        return base + longint'($urandom_range(2 * span)) - span;
    endfunction

    function automatic tri_in_t random_triangle();
        tri_in_t t;
        longint zb;
        longint cx;
        longint cy;
        int kind;
        kind = $urandom_range(9);
        zb   = jitter(longint'(lim_height), 40);
        cx   = jitter(0, 2000000);
        cy   = jitter(0, 2000000);
        case (kind)
            0, 1:
                t = make_tri($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
            2, 3, 4:    // near-level patch around the height limit
                t = make_tri(jitter(cx, 3000), jitter(cy, 3000), jitter(zb, 30),
                             jitter(cx, 3000), jitter(cy, 3000), jitter(zb, 30),
                             jitter(cx, 3000), jitter(cy, 3000), jitter(zb, 30));
            5, 6:       // sloped patch
                t = make_tri(jitter(cx, 2000), jitter(cy, 2000), jitter(zb, 2000),
                             jitter(cx, 2000), jitter(cy, 2000), jitter(zb, 2000),
                             jitter(cx, 2000), jitter(cy, 2000), jitter(zb, 2000));
            7:          // wall: nearly vertical
                t = make_tri(jitter(cx, 5), jitter(cy, 2000), jitter(zb, 3000),
                             jitter(cx, 5), jitter(cy, 2000), jitter(zb, 3000),
                             jitter(cx, 5), jitter(cy, 2000), jitter(zb, 3000));
            8:          // tiny or degenerate
                t = make_tri(jitter(cx, 1), jitter(cy, 1), jitter(zb, 1),
                             jitter(cx, 1), jitter(cy, 1), jitter(zb, 1),
                             jitter(cx, 1), jitter(cy, 1), jitter(zb, 1));
            default:    // extremes of the coordinate range
                t = make_tri(($urandom_range(1)) ? 8388607 : -8388608, jitter(0, 8000000),
                             ($urandom_range(1)) ? 8388607 : -8388608,
                             jitter(0, 8000000), ($urandom_range(1)) ? 8388607 : -8388608,
                             jitter(0, 8000000), ($urandom_range(1)) ? 8388607 : -8388608,
                             jitter(0, 8000000), ($urandom_range(1)) ? 8388607 : -8388608);
        endcase
        return t;
    endfunction

    task automatic test_directed();
        longint mx;
        longint mn;
        mx = 8388607;
        mn = -8388608;
        sender_idle_pct = 9;
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));            // zero-length normal
        send_triangle(make_tri(0, 0, 0, 1000, 0, 0, 2000, 0, 0));      // collinear
        send_triangle(make_tri(0, 0, 0, 1024, 0, 0, 0, 1024, 0));      // flat, ground
        send_triangle(make_tri(0, 0, 0, 0, 1024, 0, 1024, 0, 0));      // flat, facing down
        send_triangle(make_tri(0, 0, 600, 1024, 0, 600, 0, 1024, 600)); // flat, all raised
        send_triangle(make_tri(0, 0, 0, 1024, 0, 600, 0, 1024, 0));    // tilted, one raised
        send_triangle(make_tri(0, 0, 0, 1024, 0, 0, 0, 0, 1024));      // wall
        send_triangle(make_tri(0, 0, 0, 1024, 0, 0, 0, 1024, 400));    // moderate slope
        send_triangle(make_tri(0, 0, 0, 1024, 0, 0, 0, 1024, 3000));   // steep slope
        send_triangle(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_triangle(make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_triangle(make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn));   // largest cross product
        send_triangle(make_tri(mn, mn, 0, mx, mn, 0, mn, mx, 0));
        send_triangle(make_tri(-1, -1, -1, -1, -1, 0, 0, 0, 0));       // negative centroid
        send_triangle(make_tri(-2, 5, -7, -2, 4, -1, 1, -3, -8));
        send_triangle(make_tri(0, 0, 512, 1, 0, 512, 0, 1, 512));      // z at the limit
        send_triangle(make_tri(0, 0, 513, 1, 0, 513, 0, 1, 512));
        drain_pipeline();
    endtask

    task automatic test_random(int count, int idle_pct, bit pause_midway);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            send_triangle(random_triangle());
            if (pause_midway && i == count / 2)
                drain_pipeline();
        end
        drain_pipeline();
    endtask

    task automatic test_config_sweep();
        write_reg(REG_HEIGHT_LIMIT, 24'h800000);
        write_reg(REG_FLAT_LEVEL, 24'hFF8000);      // upper bits are dropped
        write_reg(REG_STEEP_LEVEL, 24'h004000);
        write_reg(2'd3, 24'h123456);                // unused index, ignored
        test_random(60, 9, 1'b0);
        write_reg(REG_HEIGHT_LIMIT, 24'h7FFFFF);
        write_reg(REG_FLAT_LEVEL, 24'h004000);
        write_reg(REG_STEEP_LEVEL, 24'h000000);
        test_random(60, 0, 1'b0);
        write_reg(REG_HEIGHT_LIMIT, 24'hFFFE00);
        write_reg(REG_FLAT_LEVEL, 24'h007FFF);      // above unit one
        write_reg(REG_STEEP_LEVEL, 24'hA07FFF);
        test_random(60, 80, 1'b0);
        write_reg(REG_HEIGHT_LIMIT, 24'h000000);
        write_reg(REG_FLAT_LEVEL, 24'h000000);
        write_reg(REG_STEEP_LEVEL, 24'h002000);
        test_random(60, 9, 1'b0);
        write_reg(REG_HEIGHT_LIMIT, CFG_W'($urandom));
        write_reg(REG_FLAT_LEVEL, CFG_W'($urandom));
        write_reg(REG_STEEP_LEVEL, CFG_W'($urandom));
        test_random(40, 9, 1'b0);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        vertices        = '0;
        wr_en           = 1'b0;
        wr_index        = '0;
        wr_data         = '0;
        mismatch_count  = 0;
        sent_count      = 0;
        checked_count   = 0;
        sender_idle_pct = 0;
        stall_cycles    = 0;
        lim_height      = HEIGHT_LIMIT_RST;
        lvl_flat        = FLAT_LEVEL_RST;
        lvl_steep       = STEEP_LEVEL_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(130, 9, 1'b1);      // sender mostly busy
        test_random(130, 80, 1'b0);     // sender mostly idle
        test_random(130, 0, 1'b0);      // back-to-back transfers
        test_config_sweep();

        $display("covered %0d triangles, %0d results checked, %0d mismatches",
                 sent_count, checked_count, mismatch_count);
        $display("directed edge cases, random meshes, and register sweeps at the extremes");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tnsc_pkg.sv
hw/rtl/triangle_normal_slope_classifier.sv
sim/tb_top.sv
